[sv/tkz_pkg.sv]
package tkz_pkg;

  // Default depth of the result queue (power of two, at least 2)
  localparam int unsigned OutqDepth = 4;

  // Token kind codes on the result channel
  localparam logic [1:0] KIND_WORD   = 2'd0;
  localparam logic [1:0] KIND_PUNCT  = 2'd1;
  localparam logic [1:0] KIND_SINGLE = 2'd2;
  localparam logic [1:0] KIND_PAIR   = 2'd3;

  // Byte codes that the classifier and the pair matcher look at
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_BAR   = 8'h7C;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AMP   = 8'h26;

  typedef enum logic [1:0] {
    HELD_NONE    = 2'd0,
    HELD_WORD    = 2'd1,
    HELD_STARTER = 2'd2
  } held_e;

  typedef enum logic [2:0] {
    CLS_SPACE,
    CLS_PUNCT,
    CLS_SINGLE,
    CLS_STARTER,
    CLS_WORD
  } char_class_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [7:0] token_char;
    logic [1:0] token_kind;
    logic       first_of_token;
    logic       last_of_token;
    logic       last_of_run;
  } out_item_t;

  // Results of one input transaction, handed from the lexer to the queue
  typedef struct packed {
    logic [1:0]      num;
    out_item_t [1:0] res;
  } push_t;

  function automatic char_class_e classify(input logic [7:0] c);
    char_class_e cls;
    case (c) inside
      CH_TAB, CH_LF, CH_SPACE:                           cls = CLS_SPACE;
      CH_COMMA, CH_SEMI, CH_LPAR, CH_RPAR, CH_LBRC, CH_RBRC: cls = CLS_PUNCT;
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT:      cls = CLS_SINGLE;
      CH_EQ, CH_BANG, CH_BAR, CH_LT, CH_GT, CH_AMP:      cls = CLS_STARTER;
      default:                                           cls = CLS_WORD;
    endcase
    return cls;
  endfunction

  function automatic logic is_pair(input logic [7:0] a, input logic [7:0] b);
    logic eq_pair;
    eq_pair = (a == CH_EQ || a == CH_BANG || a == CH_LT || a == CH_GT) && (b == CH_EQ);
    return eq_pair || (a == CH_BAR && b == CH_BAR) || (a == CH_AMP && b == CH_AMP);
  endfunction

endpackage

[sv/tkz_lexer.sv]
module tkz_lexer
  import tkz_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output push_t    push_o
);

  held_e      held_q, held_d;
  logic [7:0] char_q, char_d;
  logic       first_q, first_d;

  char_class_e cls;
  logic        fresh_emit;
  out_item_t   fresh_item;
  held_e       fresh_held;
  logic [7:0]  c;

  // Classify the incoming byte as if nothing were held
  always_comb begin
    c              = item_i.char_code;
    cls            = classify(c);
    fresh_emit     = (cls == CLS_PUNCT) || (cls == CLS_SINGLE);
    fresh_item     = '{token_char: c,
                       token_kind: (cls == CLS_PUNCT) ? KIND_PUNCT : KIND_SINGLE,
                       first_of_token: 1'b1, last_of_token: 1'b1, last_of_run: 1'b0};
    case (cls)
      CLS_STARTER: fresh_held = HELD_STARTER;
      CLS_WORD:    fresh_held = HELD_WORD;
      default:     fresh_held = HELD_NONE;
    endcase
  end

  // Combine the held byte with the new one: results and next held state
  always_comb begin
    push_o     = '0;
    held_d     = HELD_NONE;
    char_d     = c;
    first_d    = 1'b0;
    if (item_i.end_of_stream) begin
      char_d = '0;
      case (held_q)
        HELD_WORD: begin
          push_o.num    = 2'd1;
          push_o.res[0] = '{char_q, KIND_WORD, first_q, 1'b1, 1'b0};
        end
        HELD_STARTER: begin
          push_o.num    = 2'd1;
          push_o.res[0] = '{char_q, KIND_SINGLE, 1'b1, 1'b1, 1'b0};
        end
        default: ;
      endcase
    end else begin
      case (held_q)
        HELD_WORD: begin
          push_o.num = 2'd1;
          if (cls == CLS_WORD) begin
            push_o.res[0] = '{char_q, KIND_WORD, first_q, 1'b0, 1'b0};
            held_d        = HELD_WORD;
          end else begin
            push_o.res[0] = '{char_q, KIND_WORD, first_q, 1'b1, 1'b0};
            push_o.res[1] = fresh_item;
            push_o.num    = fresh_emit ? 2'd2 : 2'd1;
            held_d        = fresh_held;
          end
        end
        HELD_STARTER: begin
          if (is_pair(char_q, c)) begin
            push_o.num    = 2'd2;
            push_o.res[0] = '{char_q, KIND_PAIR, 1'b1, 1'b0, 1'b0};
            push_o.res[1] = '{c, KIND_PAIR, 1'b0, 1'b1, 1'b0};
          end else begin
            push_o.res[0] = '{char_q, KIND_SINGLE, 1'b1, 1'b1, 1'b0};
            push_o.res[1] = fresh_item;
            push_o.num    = fresh_emit ? 2'd2 : 2'd1;
            held_d        = fresh_held;
          end
        end
        default: begin
          push_o.res[0] = fresh_item;
          push_o.num    = fresh_emit ? 2'd1 : 2'd0;
          held_d        = fresh_held;
          first_d       = (cls == CLS_WORD);
        end
      endcase
      // A word byte taken after a starter or a dropped byte opens a new word
      if (held_q != HELD_NONE && cls == CLS_WORD && !(held_q == HELD_WORD)) begin
        first_d = 1'b1;
      end
      if (held_q == HELD_WORD && cls == CLS_WORD) begin
        first_d = 1'b0;
      end
      if (held_q == HELD_STARTER && is_pair(char_q, c)) begin
        first_d = 1'b0;
      end
    end
    // Mark the final result of this transaction
    case (push_o.num)
      2'd1:    push_o.res[0].last_of_run = 1'b1;
      2'd2:    push_o.res[1].last_of_run = 1'b1;
      default: ;
    endcase
  end

  // Hold the pending byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q  <= HELD_NONE;
      char_q  <= '0;
      first_q <= 1'b0;
    end else if (accept_i) begin
      held_q  <= held_d;
      char_q  <= char_d;
      first_q <= first_d;
    end
  end

endmodule

[sv/tkz_outq.sv]
module tkz_outq
  import tkz_pkg::*;
#(
  parameter int unsigned Depth = OutqDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_en_i,
  input  push_t     push_i,
  output logic      low_room_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] RoomLimit = CW'(Depth - 2);

  out_item_t       mem_q [Depth];
  logic [AW-1:0]   wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [1:0]      num;
  logic            pop;

  // Advance pointers and occupancy
  always_comb begin
    num         = push_en_i ? push_i.num : 2'd0;
    out_valid_o = (cnt_q != '0);
    pop         = out_valid_o && !out_stall_i;
    wr_next     = AW'(wr_q + 1'b1);
    wr_d        = AW'(wr_q + AW'(num));
    rd_d        = pop ? AW'(rd_q + 1'b1) : rd_q;
    cnt_d       = CW'(cnt_q + CW'(num) - CW'(pop));
    low_room_o  = (cnt_q > RoomLimit);
    out_item_o  = mem_q[rd_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store up to two results per transaction
  always_ff @(posedge clk_i) begin
    if (num != 2'd0) begin
      mem_q[wr_q] <= push_i.res[0];
    end
    if (num == 2'd2) begin
      mem_q[wr_next] <= push_i.res[1];
    end
  end

endmodule

[sv/char_stream_tokenizer_top.sv]
// Byte-serial tokenizer.
// Input channel: in_valid_i / in_stall_o with in_item_i carrying one text byte
// or an end-of-stream mark. A transaction happens at a rising edge with valid
// high and stall low.
// Output channel: out_valid_o / out_stall_i with out_item_o carrying one token
// character, its kind, first/last-of-token flags and a last-of-run flag on the
// final result of each input transaction. An input byte gives zero, one or two
// results.
// Results of a transaction are registered into the result queue and, if the
// queue was empty, offered on the cycle after the transaction. Throughput: one
// input byte per cycle while bytes give at most one result and in_stall_o is
// low; the output channel moves one result per cycle while out_stall_i is low.
// A QueueDepth-entry result queue lies between lexer and output; in_stall_o
// rises while it holds over QueueDepth-2 results; it depends only on occupancy.
// While the receiver stalls, the queue holds its head result unchanged and
// fills up, then the input is stalled.
// Reset empties the queue and drops any pending byte.
module char_stream_tokenizer_top
  import tkz_pkg::*;
#(
  parameter int unsigned QueueDepth = OutqDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic  accept;
  push_t push;

  assign accept = in_valid_i && !in_stall_o;

  // Classify and combine with the pending byte
  tkz_lexer u_lexer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .push_o   (push)
  );

  // Queue results toward the receiver
  tkz_outq #(
    .Depth (QueueDepth)
  ) u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_en_i   (accept),
    .push_i      (push),
    .low_room_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTH
  // An empty queue never stalls the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty result queue");

  // The second half of a two-character operator is already queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_item_o.token_kind == KIND_PAIR &&
     out_item_o.first_of_token) |=> out_valid_o)
    else $error("pair operator split across transactions");

  // A token start that is not its end is a word or a pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.first_of_token && !out_item_o.last_of_token) |->
    (out_item_o.token_kind == KIND_WORD || out_item_o.token_kind == KIND_PAIR))
    else $error("open token of a single-character kind");
`endif

endmodule
